// ----- rtl/lpd_pkg.sv -----
`default_nettype none

package lpd_pkg;

    // Field widths
    localparam int COORD_W = 20;              // point and origin coordinates, signed mm
    localparam int SKIP_W  = 10;              // skip_count register
    localparam int GAP_W   = 20;              // min_gap, max_gap, far_limit
    localparam int DIFF_W  = COORD_W + 1;     // coordinate difference
    localparam int DSQ_W   = 2 * DIFF_W;      // squared distance, sum of three squares
    localparam int SQ_W    = 2 * GAP_W;       // squared limit

    // Stream and register port widths
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;

    localparam int MAX_BEAMS_DEF = 2048;

    // Reset values
    localparam logic [SKIP_W-1:0]  SKIP_COUNT_RST = SKIP_W'(3);
    localparam logic [GAP_W-1:0]   MIN_GAP_RST    = '0;
    localparam logic [GAP_W-1:0]   MAX_GAP_RST    = '1;
    localparam logic [GAP_W-1:0]   FAR_LIMIT_RST  = '1;
    localparam logic [SQ_W-1:0]    MIN_SQ_RST     = SQ_W'(MIN_GAP_RST) * SQ_W'(MIN_GAP_RST);
    localparam logic [SQ_W-1:0]    MAX_SQ_RST     = SQ_W'(MAX_GAP_RST) * SQ_W'(MAX_GAP_RST);
    localparam logic [SQ_W-1:0]    FAR_SQ_RST     = SQ_W'(FAR_LIMIT_RST) * SQ_W'(FAR_LIMIT_RST);

    // Register map, word index (byte address = 4 * index)
    typedef enum logic [REG_IDX_W-1:0] {
        REG_SKIP_COUNT = 3'd0,
        REG_MIN_GAP    = 3'd1,
        REG_MAX_GAP    = 3'd2,
        REG_FAR_LIMIT  = 3'd3,
        REG_ORIGIN_X   = 3'd4,
        REG_ORIGIN_Y   = 3'd5,
        REG_ORIGIN_Z   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

endpackage

`default_nettype wire

// ----- rtl/lpd_dist_sq.sv -----
`default_nettype none

// Exact squared Euclidean distance between two points.
module lpd_dist_sq (
    input  wire lpd_pkg::point_t          pt_a,
    input  wire lpd_pkg::point_t          pt_b,
    output logic [lpd_pkg::DSQ_W-1:0]     dsq
);

    logic signed [lpd_pkg::DIFF_W-1:0] dx;
    logic signed [lpd_pkg::DIFF_W-1:0] dy;
    logic signed [lpd_pkg::DIFF_W-1:0] dz;
    logic signed [lpd_pkg::DSQ_W-1:0]  sx;
    logic signed [lpd_pkg::DSQ_W-1:0]  sy;
    logic signed [lpd_pkg::DSQ_W-1:0]  sz;

    always_comb begin
        dx = lpd_pkg::DIFF_W'(pt_a.x) - lpd_pkg::DIFF_W'(pt_b.x);
        dy = lpd_pkg::DIFF_W'(pt_a.y) - lpd_pkg::DIFF_W'(pt_b.y);
        dz = lpd_pkg::DIFF_W'(pt_a.z) - lpd_pkg::DIFF_W'(pt_b.z);
        sx = lpd_pkg::DSQ_W'(dx) * lpd_pkg::DSQ_W'(dx);
        sy = lpd_pkg::DSQ_W'(dy) * lpd_pkg::DSQ_W'(dy);
        sz = lpd_pkg::DSQ_W'(dz) * lpd_pkg::DSQ_W'(dz);
        // each square is below 2^40, so the sum fits without overflow
        dsq = $unsigned(sx) + $unsigned(sy) + $unsigned(sz);
    end

endmodule

`default_nettype wire

// ----- rtl/lidar_point_decimator_unit.sv -----
`default_nettype none

// LIDAR point decimator.
// Input stream (s_*): one projected point per beam. s_tdata carries x, y, z
// (20 bit signed mm each, x lowest), s_tuser carries point_valid (bit 0) and
// in_surround (bit 1), s_tlast marks the last beam of a scan.
// Result stream (m_*): one result per point. m_tdata bit 0 is keep, bit 1 is
// newly_invalid; m_tlast echoes the scan end.
// Register port (APB): skip_count, min_gap, max_gap, far_limit, origin_x/y/z
// at byte addresses 0x00..0x18. Write only while the stream is idle.
// A point accepted on s_* passes the input register and then the result
// register before its result shows on m_*.
// Throughput: one point per cycle while the receiver does not stall. The keep
// decision, which compares against the last kept point, resolves combinationally
// between the input and result registers, so consecutive points never wait on it.
// Reset (aresetn low, synchronous) empties both stages, clears the scan state
// and loads the register reset values.
// When the receiver stalls the result holds in the result register; one more
// point may still enter the input register, after which s_tready drops.
module lidar_point_decimator_unit #(
    parameter int MAX_BEAMS = lpd_pkg::MAX_BEAMS_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    // input points
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [lpd_pkg::S_TDATA_W-1:0]  s_tdata,   // point_x, point_y, point_z, zero pad
    input  wire  [lpd_pkg::S_TUSER_W-1:0]  s_tuser,   // point_valid, in_surround
    input  wire                            s_tlast,   // last_beam
    // results
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [lpd_pkg::M_TDATA_W-1:0]  m_tdata,   // keep, newly_invalid, zero pad
    output logic                           m_tlast,   // scan_end
    // register port
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [lpd_pkg::APB_AW-1:0]     paddr,
    input  wire  [lpd_pkg::APB_DW-1:0]     pwdata,
    output logic [lpd_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    localparam int IDX_W = (MAX_BEAMS > 2) ? $clog2(MAX_BEAMS) : 1;
    localparam int CMP_W = (IDX_W > lpd_pkg::SKIP_W) ? IDX_W : lpd_pkg::SKIP_W;
    localparam logic [IDX_W-1:0] BEAM_LAST = IDX_W'(MAX_BEAMS - 1);

    localparam int CW = lpd_pkg::COORD_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [lpd_pkg::SKIP_W-1:0] skip_count_reg;
    logic [lpd_pkg::GAP_W-1:0]  min_gap_reg;
    logic [lpd_pkg::GAP_W-1:0]  max_gap_reg;
    logic [lpd_pkg::GAP_W-1:0]  far_limit_reg;
    // squares kept beside the plain values so the datapath only compares
    logic [lpd_pkg::SQ_W-1:0]   min_sq_reg;
    logic [lpd_pkg::SQ_W-1:0]   max_sq_reg;
    logic [lpd_pkg::SQ_W-1:0]   far_sq_reg;
    lpd_pkg::point_t            origin_reg;

    logic                          cfg_wr;
    logic [lpd_pkg::REG_IDX_W-1:0] cfg_idx;
    logic [lpd_pkg::GAP_W-1:0]     wr_gap;
    logic [lpd_pkg::SQ_W-1:0]      wr_gap_sq;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[lpd_pkg::APB_AW-1:2];
    assign wr_gap    = pwdata[lpd_pkg::GAP_W-1:0];
    assign wr_gap_sq = lpd_pkg::SQ_W'(wr_gap) * lpd_pkg::SQ_W'(wr_gap);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_count_reg <= lpd_pkg::SKIP_COUNT_RST;
            min_gap_reg    <= lpd_pkg::MIN_GAP_RST;
            max_gap_reg    <= lpd_pkg::MAX_GAP_RST;
            far_limit_reg  <= lpd_pkg::FAR_LIMIT_RST;
            min_sq_reg     <= lpd_pkg::MIN_SQ_RST;
            max_sq_reg     <= lpd_pkg::MAX_SQ_RST;
            far_sq_reg     <= lpd_pkg::FAR_SQ_RST;
            origin_reg     <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                lpd_pkg::REG_SKIP_COUNT: skip_count_reg <= pwdata[lpd_pkg::SKIP_W-1:0];
                lpd_pkg::REG_MIN_GAP: begin
                    min_gap_reg <= wr_gap;
                    min_sq_reg  <= wr_gap_sq;
                end
                lpd_pkg::REG_MAX_GAP: begin
                    max_gap_reg <= wr_gap;
                    max_sq_reg  <= wr_gap_sq;
                end
                lpd_pkg::REG_FAR_LIMIT: begin
                    far_limit_reg <= wr_gap;
                    far_sq_reg    <= wr_gap_sq;
                end
                lpd_pkg::REG_ORIGIN_X: origin_reg.x <= pwdata[CW-1:0];
                lpd_pkg::REG_ORIGIN_Y: origin_reg.y <= pwdata[CW-1:0];
                lpd_pkg::REG_ORIGIN_Z: origin_reg.z <= pwdata[CW-1:0];
                default: ;  // address beyond the map: drop the write
            endcase
        end
    end

    // Read back; origins return sign extended.
    always_comb begin
        unique case (cfg_idx)
            lpd_pkg::REG_SKIP_COUNT: prdata = lpd_pkg::APB_DW'(skip_count_reg);
            lpd_pkg::REG_MIN_GAP:    prdata = lpd_pkg::APB_DW'(min_gap_reg);
            lpd_pkg::REG_MAX_GAP:    prdata = lpd_pkg::APB_DW'(max_gap_reg);
            lpd_pkg::REG_FAR_LIMIT:  prdata = lpd_pkg::APB_DW'(far_limit_reg);
            lpd_pkg::REG_ORIGIN_X:   prdata = lpd_pkg::APB_DW'(origin_reg.x);
            lpd_pkg::REG_ORIGIN_Y:   prdata = lpd_pkg::APB_DW'(origin_reg.y);
            lpd_pkg::REG_ORIGIN_Z:   prdata = lpd_pkg::APB_DW'(origin_reg.z);
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic            in_valid_reg;
    lpd_pkg::point_t in_pt_reg;
    logic            in_pvalid_reg;
    logic            in_surround_reg;
    logic            in_last_reg;

    logic out_valid_reg;
    logic advance;      // the input register hands its request to the result register
    logic s_accept;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_pt_reg.x     <= s_tdata[CW-1:0];
            in_pt_reg.y     <= s_tdata[2*CW-1:CW];
            in_pt_reg.z     <= s_tdata[3*CW-1:2*CW];
            in_pvalid_reg   <= s_tuser[0];
            in_surround_reg <= s_tuser[1];
            in_last_reg     <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Scan state and keep decision
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] beam_index_reg, beam_index_next;
    logic [IDX_W-1:0] kept_index_reg, kept_index_next;
    logic             have_kept_reg,  have_kept_next;
    lpd_pkg::point_t  kept_pt_reg,    kept_pt_next;

    logic [lpd_pkg::DSQ_W-1:0] d_prev;
    logic [lpd_pkg::DSQ_W-1:0] d_orig;
    logic [IDX_W-1:0]          beam_gap;
    logic                      far_enough;
    logic                      keep;
    logic                      dropped;
    logic                      step;

    lpd_dist_sq u_dist_prev (
        .pt_a (in_pt_reg),
        .pt_b (kept_pt_reg),
        .dsq  (d_prev)
    );

    lpd_dist_sq u_dist_orig (
        .pt_a (in_pt_reg),
        .pt_b (origin_reg),
        .dsq  (d_orig)
    );

    assign step = advance && in_valid_reg;

    always_comb begin
        // kept_index never exceeds beam_index while have_kept is set
        beam_gap   = beam_index_reg - kept_index_reg;
        far_enough = (CMP_W'(beam_gap) > CMP_W'(skip_count_reg))
                  || (d_prev > lpd_pkg::DSQ_W'(max_sq_reg))
                  || (d_orig > lpd_pkg::DSQ_W'(far_sq_reg));
        keep = in_pvalid_reg
            && (!in_surround_reg || !have_kept_reg
                || ((d_prev > lpd_pkg::DSQ_W'(min_sq_reg)) && far_enough));
        dropped = in_pvalid_reg && !keep;
    end

    always_comb begin
        beam_index_next = beam_index_reg;
        kept_index_next = kept_index_reg;
        have_kept_next  = have_kept_reg;
        kept_pt_next    = kept_pt_reg;
        if (step) begin
            if (keep) begin
                kept_index_next = beam_index_reg;
                kept_pt_next    = in_pt_reg;
                have_kept_next  = 1'b1;
            end
            // close the scan, or advance the beam count and hold at the top
            if (in_last_reg) begin
                beam_index_next = '0;
                have_kept_next  = 1'b0;
            end else if (beam_index_reg < BEAM_LAST) begin
                beam_index_next = beam_index_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beam_index_reg <= '0;
            kept_index_reg <= '0;
            have_kept_reg  <= 1'b0;
            kept_pt_reg    <= '0;
        end else begin
            beam_index_reg <= beam_index_next;
            kept_index_reg <= kept_index_next;
            have_kept_reg  <= have_kept_next;
            kept_pt_reg    <= kept_pt_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic out_keep_reg;
    logic out_drop_reg;
    logic out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_keep_reg <= keep;
            out_drop_reg <= dropped;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lpd_pkg::M_TDATA_W-2){1'b0}}, out_drop_reg, out_keep_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/lpd_checker.sv -----
`default_nettype none

module lpd_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_tready,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [lpd_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire                           m_tlast
);

    // results are gone after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // a point is either kept or dropped, never both
    a_keep_drop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("keep and newly_invalid both set");

    // pad bits of the result stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[lpd_pkg::M_TDATA_W-1:2] == '0))
        else $error("result pad bits set");

    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result pending");

    // a stalled result request holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind lidar_point_decimator_unit lpd_checker u_lpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- tb/sv/lidar_point_decimator_unit_tb.sv -----
`timescale 1ns / 1ps

module lidar_point_decimator_unit_tb;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int BEAM_CAP     = lpd_pkg::MAX_BEAMS_DEF - 1;
    localparam int PHASE_POINTS = 205;
    localparam int PHASES       = 8;
    localparam int NUM_REGS     = int'(lpd_pkg::REG_ORIGIN_Z) + 1;
    localparam int NUM_PROBES   = 14;
    localparam int SPAN_W       = lpd_pkg::DSQ_W + 2;

    typedef struct packed {
        logic keep;
        logic newly_invalid;
        logic scan_end;
    } verdict_t;

    // One directed request: point, flags, and a typed-in verdict where it is obvious
    typedef struct packed {
        int x;
        int y;
        int z;
        bit valid;
        bit surround;
        bit last;
        bit typed;
        bit keep;
        bit dropped;
    } probe_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    wire                           s_tready;
    logic [lpd_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [lpd_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                          s_tlast  = 1'b0;
    wire                           m_tvalid;
    logic                          m_tready = 1'b0;
    wire  [lpd_pkg::M_TDATA_W-1:0] m_tdata;
    wire                           m_tlast;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [lpd_pkg::APB_AW-1:0]    paddr    = '0;
    logic [lpd_pkg::APB_DW-1:0]    pwdata   = '0;
    wire  [lpd_pkg::APB_DW-1:0]    prdata;
    wire                           pready;

    // Register mirror and scan state of the decimation predictor
    logic [lpd_pkg::SKIP_W-1:0] cfg_skip_count;
    logic [lpd_pkg::GAP_W-1:0]  cfg_min_gap;
    logic [lpd_pkg::GAP_W-1:0]  cfg_max_gap;
    logic [lpd_pkg::GAP_W-1:0]  cfg_far_limit;
    lpd_pkg::point_t            cfg_origin;
    logic [15:0]                beam_pos;
    logic [15:0]                kept_pos;
    logic                       scan_has_kept;
    lpd_pkg::point_t            kept_point;

    verdict_t pending_verdicts[$];

    int errors        = 0;
    int points_sent   = 0;
    int scans_sent    = 0;
    int settings_used = 0;
    int kept_seen     = 0;
    int dropped_seen  = 0;
    int cycle_count   = 0;
    int tx_gap_pct    = 0;
    int rx_stall_pct  = 0;
    int rx_hold       = 0;

    // Directed stimulus, run with the reset register values.
    probe_t probes [NUM_PROBES] = '{
        '{0, 0, 0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0},         // invalid point passes untouched
        '{524287, 524287, 524287, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, // outside surround: kept
        '{-524288, -524288, -524288, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, // widest span
        '{-524288, -524288, -524288, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}, // on last kept: drop
        '{-524287, -524288, -524288, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{10, 0, 0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{10, 0, 0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
        '{11, 0, 0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},        // beam gap past skip count
        '{11, 0, 0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1},        // scan end, on last kept
        '{-3, 4, 5, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0},        // nothing kept yet in scan
        '{-1, -1, -1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},      // invalid point ends scan
        '{0, 0, 0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0},         // fresh scan again
        '{-524288, 524287, 0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{5, 5, 5, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}
    };

    always #10 aclk = ~aclk;

    lidar_point_decimator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Exact squared distance; three squares of 21 bit differences fit well in SPAN_W bits.
    function automatic logic [SPAN_W-1:0] span_sq(lpd_pkg::point_t a, lpd_pkg::point_t b);
        logic signed [SPAN_W-1:0] dx;
        logic signed [SPAN_W-1:0] dy;
        logic signed [SPAN_W-1:0] dz;
        logic [SPAN_W-1:0]        d;
        dx = SPAN_W'(a.x) - SPAN_W'(b.x);
        dy = SPAN_W'(a.y) - SPAN_W'(b.y);
        dz = SPAN_W'(a.z) - SPAN_W'(b.z);
        d = $unsigned(dx * dx + dy * dy + dz * dz);
        return d;
    endfunction

    // Decide one point and advance the scan state.
    function automatic verdict_t decimate_point(lpd_pkg::point_t pt, logic valid,
                                                logic surround, logic last);
        verdict_t                 v;
        logic [SPAN_W-1:0]        to_kept;
        logic [SPAN_W-1:0]        to_origin;
        logic [lpd_pkg::SQ_W-1:0] lo_sq;
        logic [lpd_pkg::SQ_W-1:0] hi_sq;
        logic [lpd_pkg::SQ_W-1:0] far_sq;
        logic [15:0]              beam_gap;
        v = '0;
        v.scan_end = last;
        if (valid) begin
            if (!surround || !scan_has_kept) begin
                v.keep = 1'b1;
            end else begin
                to_kept   = span_sq(pt, kept_point);
                to_origin = span_sq(pt, cfg_origin);
                lo_sq     = lpd_pkg::SQ_W'(cfg_min_gap) * lpd_pkg::SQ_W'(cfg_min_gap);
                hi_sq     = lpd_pkg::SQ_W'(cfg_max_gap) * lpd_pkg::SQ_W'(cfg_max_gap);
                far_sq    = lpd_pkg::SQ_W'(cfg_far_limit) * lpd_pkg::SQ_W'(cfg_far_limit);
                beam_gap  = beam_pos - kept_pos;
                v.keep = (to_kept > lo_sq) &&
                         (beam_gap > cfg_skip_count || to_kept > hi_sq || to_origin > far_sq);
            end
            if (v.keep) begin
                scan_has_kept = 1'b1;
                kept_pos      = beam_pos;
                kept_point    = pt;
            end else begin
                v.newly_invalid = 1'b1;
            end
        end
        if (last) begin
            beam_pos      = '0;
            scan_has_kept = 1'b0;
        end else if (beam_pos < BEAM_CAP) begin
            beam_pos = beam_pos + 1'b1;
        end
        return v;
    endfunction

    // Idle length: mostly none, then short, now and then long.
    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(60, 20);
        return $urandom_range(3, 1);
    endfunction

    // One APB transfer: setup cycle, then access until pready.
    task automatic reg_access(bit wr, lpd_pkg::reg_idx_t idx,
                              logic [lpd_pkg::APB_DW-1:0] wdata,
                              output logic [lpd_pkg::APB_DW-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write every register, read each one back, then update the mirror.
    task automatic apply_setting(int skip, int lo, int hi, int far, int ox, int oy, int oz);
        logic [lpd_pkg::APB_DW-1:0] vals  [NUM_REGS];
        logic [lpd_pkg::APB_DW-1:0] masks [NUM_REGS];
        logic [lpd_pkg::APB_DW-1:0] rd;
        lpd_pkg::reg_idx_t          ri;
        int                         i;
        vals[lpd_pkg::REG_SKIP_COUNT]  = skip;
        vals[lpd_pkg::REG_MIN_GAP]     = lo;
        vals[lpd_pkg::REG_MAX_GAP]     = hi;
        vals[lpd_pkg::REG_FAR_LIMIT]   = far;
        vals[lpd_pkg::REG_ORIGIN_X]    = ox;
        vals[lpd_pkg::REG_ORIGIN_Y]    = oy;
        vals[lpd_pkg::REG_ORIGIN_Z]    = oz;
        masks[lpd_pkg::REG_SKIP_COUNT] = (1 << lpd_pkg::SKIP_W) - 1;
        masks[lpd_pkg::REG_MIN_GAP]    = (1 << lpd_pkg::GAP_W) - 1;
        masks[lpd_pkg::REG_MAX_GAP]    = (1 << lpd_pkg::GAP_W) - 1;
        masks[lpd_pkg::REG_FAR_LIMIT]  = (1 << lpd_pkg::GAP_W) - 1;
        masks[lpd_pkg::REG_ORIGIN_X]   = (1 << lpd_pkg::COORD_W) - 1;
        masks[lpd_pkg::REG_ORIGIN_Y]   = (1 << lpd_pkg::COORD_W) - 1;
        masks[lpd_pkg::REG_ORIGIN_Z]   = (1 << lpd_pkg::COORD_W) - 1;
        for (i = 0; i < NUM_REGS; i++) begin
            reg_access(1'b1, lpd_pkg::reg_idx_t'(i), vals[i], rd);
        end
        for (i = 0; i < NUM_REGS; i++) begin
            ri = lpd_pkg::reg_idx_t'(i);
            reg_access(1'b0, ri, '0, rd);
            if (((rd ^ vals[i]) & masks[i]) != '0) begin
                $error("%s: expected %h, actual %h", ri.name(), vals[i] & masks[i],
                       rd & masks[i]);
                errors++;
            end
        end
        cfg_skip_count = vals[lpd_pkg::REG_SKIP_COUNT][lpd_pkg::SKIP_W-1:0];
        cfg_min_gap    = vals[lpd_pkg::REG_MIN_GAP][lpd_pkg::GAP_W-1:0];
        cfg_max_gap    = vals[lpd_pkg::REG_MAX_GAP][lpd_pkg::GAP_W-1:0];
        cfg_far_limit  = vals[lpd_pkg::REG_FAR_LIMIT][lpd_pkg::GAP_W-1:0];
        cfg_origin.x   = vals[lpd_pkg::REG_ORIGIN_X][lpd_pkg::COORD_W-1:0];
        cfg_origin.y   = vals[lpd_pkg::REG_ORIGIN_Y][lpd_pkg::COORD_W-1:0];
        cfg_origin.z   = vals[lpd_pkg::REG_ORIGIN_Z][lpd_pkg::COORD_W-1:0];
        settings_used++;
    endtask

    // Offer one point; hold it until accepted, then log its expected verdict.
    // tvalid stays high after the request so back-to-back points never glitch it.
    task automatic send_point(lpd_pkg::point_t pt, logic valid, logic surround, logic last,
                              bit typed, verdict_t typed_v);
        int       gap;
        verdict_t v;
        gap = pick_gap(tx_gap_pct);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(lpd_pkg::S_TDATA_W - 3 * lpd_pkg::COORD_W){1'b0}}, pt.z, pt.y, pt.x};
        s_tuser  <= {surround, valid};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        v = decimate_point(pt, valid, surround, last);
        pending_verdicts.push_back(typed ? typed_v : v);
        points_sent++;
        if (last) scans_sent++;
    endtask

    // Drop tvalid and wait until every pending verdict is matched.
    task automatic hold_for_results(int tail);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    // Random scans: points walk in steps of up to 'scale' mm from near the origin,
    // with an occasional jump anywhere in the coordinate range.
    task automatic send_scans(int n, int scale, int full_pct, int fixed_len, bit pause_mid);
        int              sent;
        int              scan_len;
        int              j;
        int              cx;
        int              cy;
        int              cz;
        lpd_pkg::point_t pt;
        logic            valid;
        logic            surround;
        logic            last;
        sent = 0;
        cx = int'(cfg_origin.x) + int'($urandom_range(4 * scale)) - 2 * scale;
        cy = int'(cfg_origin.y) + int'($urandom_range(4 * scale)) - 2 * scale;
        cz = int'(cfg_origin.z) + int'($urandom_range(4 * scale)) - 2 * scale;
        while (sent < n) begin
            if (fixed_len > 0) begin
                scan_len = fixed_len;
            end else if ($urandom_range(9) == 0) begin
                scan_len = $urandom_range(3, 1);
            end else begin
                scan_len = $urandom_range(40, 4);
            end
            for (j = 0; j < scan_len && sent < n; j++) begin
                if ($urandom_range(99) < full_pct) begin
                    pt.x = lpd_pkg::COORD_W'($urandom);
                    pt.y = lpd_pkg::COORD_W'($urandom);
                    pt.z = lpd_pkg::COORD_W'($urandom);
                end else begin
                    pt.x = lpd_pkg::COORD_W'(cx + int'($urandom_range(2 * scale)) - scale);
                    pt.y = lpd_pkg::COORD_W'(cy + int'($urandom_range(2 * scale)) - scale);
                    pt.z = lpd_pkg::COORD_W'(cz + int'($urandom_range(2 * scale)) - scale);
                end
                // keep the walk inside the 20 bit range by following the wrap
                cx = int'(pt.x);
                cy = int'(pt.y);
                cz = int'(pt.z);
                valid    = ($urandom_range(9) != 0);
                surround = ($urandom_range(4) != 0);
                last     = (j == scan_len - 1);
                send_point(pt, valid, surround, last, 1'b0, '0);
                sent++;
                if (pause_mid && sent == n / 2) hold_for_results(0);
            end
        end
    endtask

    // Receiver back-pressure, changed on the falling edge only.
    always @(negedge aclk) begin
        if (rx_hold == 0) rx_hold = pick_gap(rx_stall_pct);
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Match each accepted result against the oldest pending verdict.
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result request with no point pending: m_tdata %h, m_tlast %b",
                       m_tdata, m_tlast);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[0] !== want.keep) begin
                    $error("keep: expected %b, actual %b", want.keep, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[1] !== want.newly_invalid) begin
                    $error("newly_invalid: expected %b, actual %b", want.newly_invalid,
                           m_tdata[1]);
                    errors++;
                end
                if (m_tlast !== want.scan_end) begin
                    $error("scan_end: expected %b, actual %b", want.scan_end, m_tlast);
                    errors++;
                end
                if (m_tdata[0] === 1'b1) kept_seen++;
                if (m_tdata[1] === 1'b1) dropped_seen++;
            end
        end
    end

    // Watchdog: abort a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int              i;
        int              phase;
        int              scale;
        int              full_pct;
        int              skip;
        int              scales [4];
        lpd_pkg::point_t pt;
        verdict_t        typed_v;

        scales         = '{20, 300, 5000, 100000};
        cfg_skip_count = lpd_pkg::SKIP_COUNT_RST;
        cfg_min_gap    = lpd_pkg::MIN_GAP_RST;
        cfg_max_gap    = lpd_pkg::MAX_GAP_RST;
        cfg_far_limit  = lpd_pkg::FAR_LIMIT_RST;
        cfg_origin     = '0;
        beam_pos       = '0;
        kept_pos       = '0;
        scan_has_kept  = 1'b0;
        kept_point     = '0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed rows at reset values, no idling on either side.
        for (i = 0; i < NUM_PROBES; i++) begin
            pt.x = lpd_pkg::COORD_W'(probes[i].x);
            pt.y = lpd_pkg::COORD_W'(probes[i].y);
            pt.z = lpd_pkg::COORD_W'(probes[i].z);
            typed_v = '{probes[i].keep, probes[i].dropped, probes[i].last};
            send_point(pt, probes[i].valid, probes[i].surround, probes[i].last,
                       probes[i].typed, typed_v);
        end
        hold_for_results(4);

        // Random phases. First the low and high register extremes, then random
        // settings, last one long scan in which only distance can keep points.
        for (phase = 0; phase < PHASES; phase++) begin
            full_pct = 5;
            if (phase == 0) begin
                scale = 50;
                apply_setting(0, 0, 0, 0, 0, 0, 0);
            end else if (phase == 1) begin
                scale    = 300000;
                full_pct = 50;
                apply_setting(1023, 1048575, 1048575, 1048575, -524288, 524287, -524288);
            end else if (phase == PHASES - 1) begin
                // skip count at its top never lets the beam gap decide
                scale    = 3;
                full_pct = 0;
                apply_setting(1023, 0, 5, 1048575, 0, 0, 0);
            end else begin
                scale = scales[$urandom_range(3)];
                skip  = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(12);
                apply_setting(skip, $urandom_range(scale / 2),
                              $urandom_range(3 * scale, scale / 2),
                              $urandom_range(4 * scale),
                              int'($urandom_range(1048575)) - 524288,
                              int'($urandom_range(1048575)) - 524288,
                              int'($urandom_range(1048575)) - 524288);
            end
            if (phase % 3 == 0) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else begin
                tx_gap_pct   = $urandom_range(50, 10);
                rx_stall_pct = $urandom_range(50, 10);
            end
            if (phase == PHASES - 1) begin
                send_scans(PHASE_POINTS, scale, full_pct, PHASE_POINTS, 1'b0);
            end else begin
                send_scans(PHASE_POINTS, scale, full_pct, 0, phase == 3);
            end
            hold_for_results(4);
        end

        $display("Covered %0d points in %0d scans under %0d register settings,",
                 points_sent, scans_sent, settings_used);
        $display("one long scan kept by distance alone; %0d kept, %0d dropped, %0d mismatches.",
                 kept_seen, dropped_seen, errors);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
